### hdl/ecm_pkg.sv
package ecm_pkg;

    localparam int unsigned SCALE_W = 32;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned K_W     = 8;
    localparam int unsigned ADDR_W  = 5;

    localparam logic [ADDR_W-1:0] ADDR_K_BANDWIDTH     = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_K_LOAD          = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_K_DELAY         = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_K_RELIABILITY   = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_K_MTU           = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_REFERENCE_SCALE = 5'd20;

    localparam logic [K_W-1:0]     RST_K_BANDWIDTH     = 8'd1;
    localparam logic [K_W-1:0]     RST_K_LOAD          = 8'd0;
    localparam logic [K_W-1:0]     RST_K_DELAY         = 8'd1;
    localparam logic [K_W-1:0]     RST_K_RELIABILITY   = 8'd0;
    localparam logic [K_W-1:0]     RST_K_MTU           = 8'd0;
    localparam logic [SCALE_W-1:0] RST_REFERENCE_SCALE = 32'd10000000;

    localparam logic [23:0] METRIC_CAP  = 24'hFFFFFF;
    localparam logic [31:0] UNREACHABLE = 32'hFFFFFFFF;

    // Worst-case sum: 255*2^32 + 255*2^32 + 255*2^32 < 2^42; times K5 < 2^50.
    localparam int unsigned SUM_W  = 42;
    localparam int unsigned PROD_W = 50;

endpackage

### hdl/eigrp_composite_metric.sv
// EIGRP composite metric, one path per transaction.
// Input channel: i_link_bandwidth, i_link_load, i_path_delay, i_link_reliability
// with i_valid / o_stall. Output channel: o_metric with o_valid / i_stall.
// Configuration: APB-style port, K1..K5 at 0x00..0x10, reference scale at 0x14.
// Throughput: one transaction per cycle while no output stall freezes the pipeline.
// The pipeline is made of the three bit-serial divider pipelines
// (32 + 40 + 50 stages) plus the product, sum, scale and output registers.
// Reset returns the K values and reference scale to their defaults and empties
// the pipeline. Whenever i_stall is high with a result waiting, the whole
// pipeline freezes and o_stall rises; nothing is dropped or repeated.
module eigrp_composite_metric (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [31:0]                   i_link_bandwidth,
    input  logic [7:0]                    i_link_load,
    input  logic [31:0]                   i_path_delay,
    input  logic [7:0]                    i_link_reliability,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [31:0]                   o_metric,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecm_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ecm_pkg::*;

    logic [K_W-1:0]     r_k1, r_k2, r_k3, r_k4, r_k5;
    logic [SCALE_W-1:0] r_scale;
    logic               w_wr;
    logic               w_adv;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1    <= RST_K_BANDWIDTH;
            r_k2    <= RST_K_LOAD;
            r_k3    <= RST_K_DELAY;
            r_k4    <= RST_K_RELIABILITY;
            r_k5    <= RST_K_MTU;
            r_scale <= RST_REFERENCE_SCALE;
        end else if (w_wr) begin
            unique case (paddr)
                ADDR_K_BANDWIDTH:     r_k1 <= pwdata[K_W-1:0];
                ADDR_K_LOAD:          r_k2 <= pwdata[K_W-1:0];
                ADDR_K_DELAY:         r_k3 <= pwdata[K_W-1:0];
                ADDR_K_RELIABILITY:   r_k4 <= pwdata[K_W-1:0];
                ADDR_K_MTU:           r_k5 <= pwdata[K_W-1:0];
                ADDR_REFERENCE_SCALE: r_scale <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_K_BANDWIDTH:     prdata = 32'(r_k1);
            ADDR_K_LOAD:          prdata = 32'(r_k2);
            ADDR_K_DELAY:         prdata = 32'(r_k3);
            ADDR_K_RELIABILITY:   prdata = 32'(r_k4);
            ADDR_K_MTU:           prdata = 32'(r_k5);
            ADDR_REFERENCE_SCALE: prdata = r_scale;
            default:              prdata = '0;
        endcase
    end

    logic r_ov;
    assign w_adv   = !(r_ov && i_stall);
    assign o_stall = !w_adv;

    // Stage A: bandwidth term divider; tag carries load, delay, rel, unreachable.
    localparam int unsigned TA_W = 8 + 32 + 8 + 1;
    logic            a_v;
    logic [31:0]     a_bwt;
    logic [TA_W-1:0] a_tag;

    ecm_divider #(.NUM_W(32), .DEN_W(32), .TAG_W(TA_W)) u_div_bw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_valid(i_valid), .i_num(r_scale), .i_den(i_link_bandwidth),
        .i_tag({i_link_load, i_path_delay, i_link_reliability, i_link_bandwidth == '0}),
        .o_valid(a_v), .o_quot(a_bwt), .o_tag(a_tag)
    );

    // Stage B: products.
    logic        r_bv, r_bun;
    logic [39:0] r_k1b, r_k2b, r_k3d;
    logic [8:0]  r_lden;
    logic [7:0]  r_brel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (w_adv) r_bv <= a_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k1b  <= 40'(a_bwt) * 40'(r_k1);
            r_k2b  <= 40'(a_bwt) * 40'(r_k2);
            r_k3d  <= 40'(a_tag[40:9]) * 40'(r_k3);
            r_lden <= 9'd256 - 9'(a_tag[48:41]);
            r_brel <= a_tag[8:1];
            r_bun  <= a_tag[0];
        end
    end

    // Stage C: load-scaled term divider.
    localparam int unsigned TC_W = 40 + 40 + 8 + 1;
    logic            c_v;
    logic [39:0]     c_q;
    logic [TC_W-1:0] c_tag;

    ecm_divider #(.NUM_W(40), .DEN_W(9), .TAG_W(TC_W)) u_div_load (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_valid(r_bv), .i_num(r_k2b), .i_den(r_lden),
        .i_tag({r_k1b, r_k3d, r_brel, r_bun}),
        .o_valid(c_v), .o_quot(c_q), .o_tag(c_tag)
    );

    // Stage D: sum.
    logic              r_dv, r_dun;
    logic [SUM_W-1:0]  r_sum;
    logic [7:0]        r_drel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (w_adv) r_dv <= c_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum  <= SUM_W'(c_tag[88:49]) + SUM_W'(c_tag[48:9]) + SUM_W'(c_q);
            r_drel <= c_tag[8:1];
            r_dun  <= c_tag[0];
        end
    end

    // Stage E: scale by K5, form divisor.
    logic              r_ev, r_eun, r_escl;
    logic [PROD_W-1:0] r_prod;
    logic [8:0]        r_eden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev <= 1'b0;
        else if (w_adv) r_ev <= r_dv;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_eden <= 9'(r_drel) + 9'(r_k4);
            r_escl <= (r_k5 != '0) && ((9'(r_drel) + 9'(r_k4)) != '0);
            r_prod <= (r_k5 != '0 && (9'(r_drel) + 9'(r_k4)) != '0)
                      ? PROD_W'(r_sum) * PROD_W'(r_k5) : PROD_W'(r_sum);
            r_eun  <= r_dun;
        end
    end

    // Stage F: reliability divider (divide by one when scaling is off).
    logic              f_v;
    logic [PROD_W-1:0] f_q;
    logic              f_un;

    ecm_divider #(.NUM_W(PROD_W), .DEN_W(9), .TAG_W(1)) u_div_rel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_valid(r_ev), .i_num(r_prod), .i_den(r_escl ? r_eden : 9'd1),
        .i_tag(r_eun),
        .o_valid(f_v), .o_quot(f_q), .o_tag(f_un)
    );

    // Output register: saturate and shift.
    logic [31:0] r_met;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= f_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (f_un) r_met <= UNREACHABLE;
            else if (f_q > PROD_W'(METRIC_CAP)) r_met <= {METRIC_CAP, 8'h00};
            else r_met <= {f_q[23:0], 8'h00};
        end
    end

    assign o_valid  = r_ov;
    assign o_metric = r_met;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_metric))
        else $error("output changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall mismatch");
    a_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_metric != UNREACHABLE |-> o_metric[7:0] == 8'h00)
        else $error("metric not multiple of 256");
endmodule

### hdl/ecm_divider.sv
module ecm_divider #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 32,
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    // One quotient bit per stage, restoring division, den of zero gives all ones.
    localparam int unsigned REM_W = DEN_W + 1;

    logic             r_vld [NUM_W+1];
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [NUM_W-1:0] r_quo [NUM_W+1];
    logic [REM_W-1:0] r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_num[0] = i_num;
        r_quo[0] = '0;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [REM_W-1:0] w_sh;
        logic             w_ge;
        assign w_sh = {r_rem[s][REM_W-2:0], r_num[s][NUM_W-1-s]};
        assign w_ge = w_sh >= {1'b0, r_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
                r_rem[s+1] <= w_ge ? w_sh - {1'b0, r_den[s]} : w_sh;
                r_quo[s+1] <= r_quo[s] | (NUM_W'(w_ge) << (NUM_W-1-s));
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_quo[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ecm_pkg::*;

    localparam int LATENCY   = 126;
    localparam int MAX_CYCLE = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [31:0]          i_link_bandwidth = '0;
    logic [7:0]           i_link_load = '0;
    logic [31:0]          i_path_delay = '0;
    logic [7:0]           i_link_reliability = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [31:0]          o_metric;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    eigrp_composite_metric DUT (.*);

    logic [7:0]  k1, k2, k3, k4, k5;
    logic [31:0] ref_scale;

    logic [31:0] metric_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycle = 0;
    int          hold_off = 0;
    bit          stall_random = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] composite_metric(logic [31:0] bw, logic [7:0] load,
                                                     logic [31:0] delay, logic [7:0] rel);
        logic [63:0] bwterm, total, divisor;
        if (bw == 0)
            return 32'hFFFFFFFF;
        bwterm = (ref_scale == 0) ? 64'd0 : {32'd0, ref_scale} / {32'd0, bw};
        total = k1 * bwterm + (k2 * bwterm) / (64'd256 - load) + k3 * {32'd0, delay};
        divisor = rel + k4;
        if (k5 != 0 && divisor > 0)
            total = (total * k5) / divisor;
        if (total > 64'd16777215)
            total = 64'd16777215;
        return total[23:0] * 32'd256;
    endfunction

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if (stall_random) begin
            i_stall <= ($urandom_range(0, 99) < 30);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (metric_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected transaction: metric %h", o_metric);
            end else begin
                if (o_metric !== metric_q[0]) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("metric mismatch: expected %h actual %h",
                                 metric_q[0], o_metric);
                end
                void'(metric_q.pop_front());
            end
        end
    end

    task automatic send_path(logic [31:0] bw, logic [7:0] load, logic [31:0] delay,
                             logic [7:0] rel);
        i_valid <= 1'b1;
        i_link_bandwidth <= bw;
        i_link_load <= load;
        i_path_delay <= delay;
        i_link_reliability <= rel;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        metric_q.push_back(composite_metric(bw, load, delay, rel));
        items_sent++;
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        idle_input();
        n = 0;
        while (metric_q.size() != 0 && n < 50000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_weights(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                               logic [7:0] d, logic [7:0] e, logic [31:0] s);
        drain();
        apb_write(ADDR_K_BANDWIDTH, {24'd0, a});
        apb_write(ADDR_K_LOAD, {24'd0, b});
        apb_write(ADDR_K_DELAY, {24'd0, c});
        apb_write(ADDR_K_RELIABILITY, {24'd0, d});
        apb_write(ADDR_K_MTU, {24'd0, e});
        apb_write(ADDR_REFERENCE_SCALE, s);
        k1 = a; k2 = b; k3 = c; k4 = d; k5 = e; ref_scale = s;
    endtask

    task automatic random_path();
        logic [31:0] bw, delay;
        case ($urandom_range(0, 5))
            0: bw = 32'd0;
            1: bw = $urandom_range(1, 1000);
            2: bw = 32'hFFFFFFFF;
            default: bw = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: delay = $urandom_range(0, 100000);
            1: delay = 32'hFFFFFFFF;
            default: delay = $urandom;
        endcase
        send_path(bw, 8'($urandom_range(0, 255)), delay, 8'($urandom_range(0, 255)));
    endtask

    task automatic bursty_paths(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                random_path();
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_input();
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_reset_defaults();
        k1 = RST_K_BANDWIDTH; k2 = RST_K_LOAD; k3 = RST_K_DELAY;
        k4 = RST_K_RELIABILITY; k5 = RST_K_MTU; ref_scale = RST_REFERENCE_SCALE;
        send_path(32'd0, 8'd0, 32'd0, 8'd0);
        send_path(32'd1, 8'd0, 32'd0, 8'd0);
        send_path(32'd10000, 8'd128, 32'd2560, 8'd255);
        send_path(32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 8'hFF);
        idle_input();
    endtask

    task automatic test_directed_cases();
        set_weights(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 32'hFFFFFFFF);
        send_path(32'd1, 8'd255, 32'hFFFFFFFF, 8'd1);
        send_path(32'd1, 8'd0, 32'd0, 8'd0);
        send_path(32'd7, 8'd255, 32'd3, 8'd255);
        send_path(32'd0, 8'd255, 32'hFFFFFFFF, 8'd255);
        set_weights(8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 32'd0);
        send_path(32'd5, 8'd255, 32'd100, 8'd0);
        send_path(32'd5, 8'd0, 32'd1, 8'd1);
        send_path(32'hFFFFFFFF, 8'd0, 32'd0, 8'd255);
        set_weights(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 32'd1);
        send_path(32'd1, 8'd0, 32'd0, 8'd0);
        send_path(32'd2, 8'd255, 32'hFFFFFFFF, 8'd255);
        set_weights(8'd3, 8'd17, 8'd1, 8'd255, 8'd200, 32'd10000000);
        send_path(32'd1000, 8'd100, 32'd12345, 8'd255);
        send_path(32'd99, 8'd1, 32'd65536, 8'd0);
        idle_input();
    endtask

    task automatic test_random_settings();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            set_weights(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : $urandom);
            stall_random = (phase % 2 == 1);
            bursty_paths(150);
        end
        stall_random = 1'b1;
    endtask

    task automatic test_backpressure();
        set_weights(8'd1, 8'd2, 8'd1, 8'd10, 8'd3, 32'd10000000);
        stall_random = 1'b0;
        hold_off = 300;
        repeat (200) random_path();
        idle_input();
        stall_random = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_cases();
        test_random_settings();
        test_backpressure();
        drain();
        $display("Sent %0d paths over reset, directed and 8 random weight settings,", items_sent);
        $display("with bursty input, random and long output stalls; %0d results checked.",
                 results_seen);
        if (mismatches == 0 && metric_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
